@@ rtl/running_mean_variance_unit_assert.svh @@
// Assertion macros used by the checker file.
`ifndef RUNNING_MEAN_VARIANCE_UNIT_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_UNIT_ASSERT_SVH

// An implication checked at every rising edge outside reset.
`define RMV_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");

// A next-cycle implication checked at every rising edge outside reset.
`define RMV_ASSERT_NXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ rtl/rmv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rmv_pkg;
    localparam int MEAN_GUARD = 16;
    localparam int MEAN_W = 48;
    localparam int SSD_W = 64;
    localparam int VAR_W = 48;
    localparam int DATA_W = 32;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV1, ST_MEAN, ST_MUL, ST_ACC, ST_DIV2, ST_SQRT, ST_OUT
    } rmv_state_t;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_CLEAR = 1'b1;
endpackage
`default_nettype wire

@@ rtl/running_mean_variance_unit.sv @@
// Running mean and variance (Welford) over signed fixed-point samples.
// Input channel s_*: op selects push (sample taken) or clear (statistics zeroed).
// Result channel m_*: one result per input transfer with count, mean,
// sample variance, standard deviation and a sticky saturation flag.
// An item is worked out by one shared shift/subtract unit under a small
// sequencer: a 64-step restoring division for the mean update, a 48-step
// shift-add multiply for the squared deviation, a 64-step division for the
// variance and a 32-step bitwise square root. A push runs the mean division,
// the multiply and the accumulate; a push ignored at the count limit skips
// these, and a clear goes straight to the result. Once the count is two or
// more, the variance division and the root follow. s_ready is high only in
// idle; the next item is taken in the cycle after the result transfer at the
// earliest, and a stalled receiver holds the block.
// Reset (aresetn low, synchronous) zeroes the statistics and the flag and
// empties the output register.
`timescale 1ns / 1ps
`default_nettype none
module running_mean_variance_unit
    import rmv_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_op,
    input  wire logic signed [31:0]  s_sample,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [31:0]              m_count,
    output logic signed [31:0]       m_mean,
    output logic [47:0]              m_variance,
    output logic [31:0]              m_stddev,
    output logic                     m_saturated
);
    localparam int SHR = 2 * MEAN_GUARD + FRAC_BITS;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    rmv_state_t state_reg, state_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic signed [MEAN_W-1:0] mean_reg, mean_next;
    logic [SSD_W-1:0] ssd_reg, ssd_next;
    logic sat_reg, sat_next;
    logic signed [MEAN_W-1:0] xs_reg, xs_next;
    logic d1neg_reg, d1neg_next;
    // Shared shift/subtract datapath registers.
    logic [63:0] num_reg, num_next;       // dividend shifting out / multiplier
    logic [63:0] rem_reg, rem_next;       // remainder / root candidate
    logic [127:0] acc_reg, acc_next;      // quotient / product / radicand
    logic [63:0] den_reg, den_next;       // divisor / multiplicand
    logic [6:0] step_reg, step_next;
    logic m_valid_reg, m_valid_next;
    logic [31:0] o_cnt_reg, o_cnt_next;
    logic signed [31:0] o_mean_reg, o_mean_next;
    logic [47:0] o_var_reg, o_var_next;
    logic [31:0] o_sd_reg, o_sd_next;
    logic o_sat_reg, o_sat_next;

    logic [64:0] rem_sh;
    logic signed [MEAN_W:0] d_wide;
    logic [MEAN_W-1:0] d_mag;
    logic [127:0] prod_rnd;
    logic [64:0] ssd_sum;
    logic signed [MEAN_W-1:0] mrnd;
    logic signed [MEAN_W-MEAN_GUARD-1:0] mshift;
    logic [31:0] sq_cand;
    logic [63:0] sq_lhs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            mean_reg <= '0;
            ssd_reg <= '0;
            sat_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            mean_reg <= mean_next;
            ssd_reg <= ssd_next;
            sat_reg <= sat_next;
            m_valid_reg <= m_valid_next;
        end
        xs_reg <= xs_next;
        d1neg_reg <= d1neg_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        den_reg <= den_next;
        step_reg <= step_next;
        o_cnt_reg <= o_cnt_next;
        o_mean_reg <= o_mean_next;
        o_var_reg <= o_var_next;
        o_sd_reg <= o_sd_next;
        o_sat_reg <= o_sat_next;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        mean_next = mean_reg;
        ssd_next = ssd_reg;
        sat_next = sat_reg;
        xs_next = xs_reg;
        d1neg_next = d1neg_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        acc_next = acc_reg;
        den_next = den_reg;
        step_next = step_reg;
        m_valid_next = m_valid_reg;
        o_cnt_next = o_cnt_reg;
        o_mean_next = o_mean_reg;
        o_var_next = o_var_reg;
        o_sd_next = o_sd_reg;
        o_sat_next = o_sat_reg;
        s_ready = (state_reg == ST_IDLE) && !m_valid_reg;

        rem_sh = {rem_reg, num_reg[63]};
        d_wide = MEAN_W'(xs_reg) - MEAN_W'(mean_reg);
        d_mag = d_wide[MEAN_W] ? MEAN_W'(-d_wide) : d_wide[MEAN_W-1:0];
        prod_rnd = acc_reg + (128'd1 << (SHR - 1));
        ssd_sum = {1'b0, ssd_reg} + {1'b0, prod_rnd[SHR +: 64]};
        mrnd = mean_reg + (MEAN_W'(1) <<< (MEAN_GUARD - 1));
        mshift = mrnd[MEAN_W-1:MEAN_GUARD];
        sq_cand = rem_reg[31:0] | (32'd1 << step_reg[4:0]);
        sq_lhs = 64'(sq_cand) * 64'(sq_cand);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    xs_next = MEAN_W'(s_sample) <<< MEAN_GUARD;
                    if (s_op == OP_CLEAR) begin
                        cnt_next = '0;
                        mean_next = '0;
                        ssd_next = '0;
                        sat_next = 1'b0;
                        state_next = ST_OUT;
                    end else if (cnt_reg == CNT_MAX) begin
                        state_next = ST_OUT;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg + 1'b1 == CNT_MAX) sat_next = 1'b1;
                        state_next = ST_DIV1;
                        step_next = '0;
                    end
                end
            end
            ST_DIV1: begin
                // Load |d1| / count, then 64 restoring steps.
                if (step_reg == 7'd0) begin
                    d1neg_next = d_wide[MEAN_W];
                    num_next = 64'(d_mag);
                    den_next = 64'(cnt_reg);
                    rem_next = '0;
                    acc_next = '0;
                    step_next = 7'd1;
                end else begin
                    num_next = num_reg << 1;
                    if (rem_sh >= {1'b0, den_reg}) begin
                        rem_next = 64'(rem_sh - {1'b0, den_reg});
                        acc_next = {acc_reg[126:0], 1'b1};
                    end else begin
                        rem_next = rem_sh[63:0];
                        acc_next = {acc_reg[126:0], 1'b0};
                    end
                    if (step_reg == 7'd64) state_next = ST_MEAN;
                    else step_next = step_reg + 1'b1;
                end
            end
            ST_MEAN: begin
                mean_next = d1neg_reg ? mean_reg - MEAN_W'(acc_reg[63:0])
                                      : mean_reg + MEAN_W'(acc_reg[63:0]);
                num_next = {16'd0, d_mag};
                state_next = ST_MUL;
                step_next = '0;
            end
            ST_MUL: begin
                // d2 magnitude loaded first, then shift-add over 48 bits.
                if (step_reg == 7'd0) begin
                    den_next = {16'd0, d_mag};
                    acc_next = '0;
                    step_next = 7'd1;
                end else begin
                    if (num_reg[0]) acc_next = acc_reg + ({64'd0, den_reg} << (step_reg - 1));
                    num_next = num_reg >> 1;
                    if (step_reg == 7'(MEAN_W)) state_next = ST_ACC;
                    else step_next = step_reg + 1'b1;
                end
            end
            ST_ACC: begin
                if ((prod_rnd >> SHR) >> 64 != 0 || ssd_sum[64]) begin
                    ssd_next = '1;
                    sat_next = 1'b1;
                end else begin
                    ssd_next = ssd_sum[63:0];
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                o_cnt_next = (COUNT_WIDTH > 32 && (cnt_reg >> 32) != 0) ? 32'hFFFF_FFFF
                                                                     : 32'(cnt_reg);
                o_sat_next = sat_reg;
                o_var_next = '0;
                o_sd_next = '0;
                if (cnt_reg == '0) o_mean_next = '0;
                else if (mshift > 33'sh7FFF_FFFF) o_mean_next = 32'sh7FFF_FFFF;
                else if (mshift < -33'sh8000_0000) o_mean_next = -32'sh8000_0000;
                else o_mean_next = 32'(mshift);
                if (cnt_reg >= COUNT_WIDTH'(2)) begin
                    state_next = ST_DIV2;
                    step_next = '0;
                end else begin
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV2: begin
                if (step_reg == 7'd0) begin
                    num_next = ssd_reg;
                    den_next = 64'(cnt_reg - 1'b1);
                    rem_next = '0;
                    acc_next = '0;
                    step_next = 7'd1;
                end else begin
                    num_next = num_reg << 1;
                    if (rem_sh >= {1'b0, den_reg}) begin
                        rem_next = 64'(rem_sh - {1'b0, den_reg});
                        acc_next = {acc_reg[126:0], 1'b1};
                    end else begin
                        rem_next = rem_sh[63:0];
                        acc_next = {acc_reg[126:0], 1'b0};
                    end
                    if (step_reg == 7'd64) begin
                        state_next = ST_SQRT;
                        step_next = 7'd31;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_SQRT: begin
                // First cycle clamps the quotient; then one root bit per cycle.
                if (rem_reg[63] || step_reg == 7'd31 && acc_reg[127]) begin
                    rem_next = '0;
                end
                if (step_reg == 7'd31 && !acc_reg[127]) begin
                    o_var_next = (acc_reg[63:48] != 0) ? 48'hFFFF_FFFF_FFFF : acc_reg[47:0];
                    acc_next = {1'b1, 63'd0, ((acc_reg[63:48] != 0) ? 16'd0 : 16'd0),
                                (acc_reg[63:48] != 0) ? 48'hFFFF_FFFF_FFFF : acc_reg[47:0]};
                    rem_next = '0;
                end else begin
                    if ((sq_lhs >> FRAC_BITS) <= {16'd0, acc_reg[47:0]})
                        rem_next = 64'(sq_cand);
                    else rem_next = rem_reg;
                    o_sd_next = ((sq_lhs >> FRAC_BITS) <= {16'd0, acc_reg[47:0]})
                                ? sq_cand : rem_reg[31:0];
                    if (step_reg == 7'd0) begin
                        m_valid_next = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        step_next = step_reg - 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_count = o_cnt_reg;
    assign m_mean = o_mean_reg;
    assign m_variance = o_var_reg;
    assign m_stddev = o_sd_reg;
    assign m_saturated = o_sat_reg;
endmodule
`default_nettype wire

@@ rtl/rmv_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "running_mean_variance_unit_assert.svh"
module rmv_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_count,
    input wire logic [47:0] m_variance,
    input wire logic [31:0] m_stddev
);
    // The block never takes a new item while a result waits.
    `RMV_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_valid, !s_ready)
    // A single accepted item cannot produce a result in the next cycle.
    `RMV_ASSERT_NXT(a_min_latency, aclk, aresetn, s_valid && s_ready, !m_valid)
    // Below two samples the spread reads zero.
    `RMV_ASSERT_IMP(a_var_zero, aclk, aresetn, m_valid && m_count < 32'd2,
                    m_variance == 48'd0 && m_stddev == 32'd0)
    // A stalled result holds.
    `RMV_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_count))
endmodule

bind running_mean_variance_unit rmv_checker u_rmv_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_count(m_count),
    .m_variance(m_variance), .m_stddev(m_stddev)
);
`default_nettype wire
